>>> sv/rcpmog_pkg.sv
// shared types and constants for the rc pulse motor overcurrent guard
// no dependencies
`default_nettype none

package rcpmog_pkg;

    localparam int unsigned PULSE_LOW_US  = 800;
    localparam int unsigned PULSE_HIGH_US = 2200;
    localparam int unsigned FORWARD_LEVEL = 255;
    localparam int unsigned REVERSE_LEVEL = 255;

    localparam logic signed [8:0] SPEED_FWD  = 9'(FORWARD_LEVEL);
    localparam logic signed [8:0] SPEED_REV  = -(9'(REVERSE_LEVEL));
    localparam logic signed [8:0] SPEED_STOP = 9'sd0;

    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_CMD_MIN     = 3'd1,
        REG_CMD_MAX     = 3'd2,
        REG_DZ_LOW      = 3'd3,
        REG_DZ_HIGH     = 3'd4,
        REG_START_BLANK = 3'd5,
        REG_CUR_LIMIT   = 3'd6,
        REG_SENSOR      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_CTRL = 1'b1
    } t_op;

    typedef struct packed {
        logic [15:0] edge_gap_us;
        logic [15:0] command_min_us;
        logic [15:0] command_max_us;
        logic [15:0] deadzone_low_us;
        logic [15:0] deadzone_high_us;
        logic [15:0] start_blank_ms;
        logic [11:0] current_limit_ma;
        logic        sensor_present;
    } t_cfg;

    typedef struct packed {
        logic        pending;
        logic [15:0] width;
    } t_pulse;

    typedef struct packed {
        logic signed [8:0] speed;
        logic              tripped;
        logic              blanking;
    } t_motor;

endpackage

`default_nettype wire

>>> sv/rcpmog_regs.sv
// configuration register file behind the apb-style port
// depends on rcpmog_pkg
`default_nettype none

module rcpmog_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rcpmog_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    output rcpmog_pkg::t_cfg                        o_cfg
);
    import rcpmog_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_gap_us      <= 16'd50;
            r_cfg.command_min_us   <= 16'd900;
            r_cfg.command_max_us   <= 16'd2100;
            r_cfg.deadzone_low_us  <= 16'd1400;
            r_cfg.deadzone_high_us <= 16'd1600;
            r_cfg.start_blank_ms   <= 16'd200;
            r_cfg.current_limit_ma <= 12'd800;
            r_cfg.sensor_present   <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE:    r_cfg.edge_gap_us      <= pwdata[15:0];
                REG_CMD_MIN:     r_cfg.command_min_us   <= pwdata[15:0];
                REG_CMD_MAX:     r_cfg.command_max_us   <= pwdata[15:0];
                REG_DZ_LOW:      r_cfg.deadzone_low_us  <= pwdata[15:0];
                REG_DZ_HIGH:     r_cfg.deadzone_high_us <= pwdata[15:0];
                REG_START_BLANK: r_cfg.start_blank_ms   <= pwdata[15:0];
                REG_CUR_LIMIT:   r_cfg.current_limit_ma <= pwdata[11:0];
                REG_SENSOR:      r_cfg.sensor_present   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE:    prdata = {16'd0, r_cfg.edge_gap_us};
            REG_CMD_MIN:     prdata = {16'd0, r_cfg.command_min_us};
            REG_CMD_MAX:     prdata = {16'd0, r_cfg.command_max_us};
            REG_DZ_LOW:      prdata = {16'd0, r_cfg.deadzone_low_us};
            REG_DZ_HIGH:     prdata = {16'd0, r_cfg.deadzone_high_us};
            REG_START_BLANK: prdata = {16'd0, r_cfg.start_blank_ms};
            REG_CUR_LIMIT:   prdata = {20'd0, r_cfg.current_limit_ma};
            REG_SENSOR:      prdata = {31'd0, r_cfg.sensor_present};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rcpmog_pulse.sv
// pin edge debounce and pulse width capture, holds the pending width
// depends on rcpmog_pkg
`default_nettype none

module rcpmog_pulse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_op,
    input  wire logic [31:0]        i_time_us,
    input  wire logic               i_pin_level,
    input  wire logic [15:0]        i_edge_gap_us,
    output rcpmog_pkg::t_pulse      o_pulse,
    output logic      [15:0]        o_held_next
);
    import rcpmog_pkg::*;

    logic [31:0] r_last_edge_us;
    logic        r_awaiting_rise;
    logic [31:0] r_rise_us;
    logic [15:0] r_held_width;
    logic        r_width_pending;

    logic [31:0] n_last_edge_us;
    logic        n_awaiting_rise;
    logic [31:0] n_rise_us;
    logic [15:0] n_held_width;
    logic        n_width_pending;

    logic [31:0] w_gap;
    logic [31:0] w_width;

    assign w_gap   = i_time_us - r_last_edge_us;
    assign w_width = i_time_us - r_rise_us;

    always_comb begin
        n_last_edge_us  = r_last_edge_us;
        n_awaiting_rise = r_awaiting_rise;
        n_rise_us       = r_rise_us;
        n_held_width    = r_held_width;
        n_width_pending = r_width_pending;
        if (t_op'(i_op) == OP_CTRL) begin
            // control step consumes the pending width
            n_width_pending = 1'b0;
        end else if (w_gap >= {16'd0, i_edge_gap_us}) begin
            n_last_edge_us = i_time_us;
            if (i_pin_level && r_awaiting_rise) begin
                n_rise_us       = i_time_us;
                n_awaiting_rise = 1'b0;
            end else if (!i_pin_level && !r_awaiting_rise) begin
                if (w_width >= 32'(PULSE_LOW_US) && w_width <= 32'(PULSE_HIGH_US)) begin
                    n_held_width    = w_width[15:0];
                    n_width_pending = 1'b1;
                end
                n_awaiting_rise = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge_us  <= 32'd0;
            r_awaiting_rise <= 1'b1;
            r_rise_us       <= 32'd0;
            r_held_width    <= 16'd0;
            r_width_pending <= 1'b0;
        end else if (i_step) begin
            r_last_edge_us  <= n_last_edge_us;
            r_awaiting_rise <= n_awaiting_rise;
            r_rise_us       <= n_rise_us;
            r_held_width    <= n_held_width;
            r_width_pending <= n_width_pending;
        end
    end

    assign o_pulse.pending = r_width_pending;
    assign o_pulse.width   = r_held_width;
    assign o_held_next     = n_held_width;

endmodule

`default_nettype wire

>>> sv/rcpmog_prot.sv
// start blanking, overcurrent trip and command decode through the dead zone
// depends on rcpmog_pkg
`default_nettype none

module rcpmog_prot (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_op,
    input  wire logic [31:0]        i_time_ms,
    input  wire logic signed [12:0] i_current_ma,
    input  rcpmog_pkg::t_cfg        i_cfg,
    input  rcpmog_pkg::t_pulse      i_pulse,
    output rcpmog_pkg::t_motor      o_motor_next
);
    import rcpmog_pkg::*;

    logic signed [8:0] r_drive_speed;
    logic signed [8:0] r_commanded_speed;
    logic              r_trip_latched;
    t_dir              r_trip_direction;
    logic              r_running;
    logic [31:0]       r_start_ms;
    logic              r_in_blanking;

    logic signed [8:0] n_drive_speed;
    logic signed [8:0] n_commanded_speed;
    logic              n_trip_latched;
    t_dir              n_trip_direction;
    logic              n_running;
    logic [31:0]       n_start_ms;
    logic              n_in_blanking;

    logic signed [12:0] w_limit;
    logic               w_over;
    logic signed [8:0]  w_cmd;
    logic               w_in_range;

    assign w_limit    = $signed({1'b0, i_cfg.current_limit_ma});
    assign w_over     = i_current_ma >= w_limit;
    assign w_in_range = i_pulse.width >= i_cfg.command_min_us &&
                        i_pulse.width <= i_cfg.command_max_us;

    always_comb begin
        n_drive_speed     = r_drive_speed;
        n_commanded_speed = r_commanded_speed;
        n_trip_latched    = r_trip_latched;
        n_trip_direction  = r_trip_direction;
        n_running         = r_running;
        n_start_ms        = r_start_ms;
        n_in_blanking     = r_in_blanking;
        w_cmd             = SPEED_STOP;

        if (t_op'(i_op) == OP_CTRL) begin
            // protection check
            if (i_cfg.sensor_present) begin
                if (r_drive_speed != SPEED_STOP) begin
                    if (!r_running) begin
                        n_start_ms    = i_time_ms;
                        n_running     = 1'b1;
                        n_in_blanking = 1'b1;
                    end
                    if (n_in_blanking &&
                        (i_time_ms - n_start_ms) >= {16'd0, i_cfg.start_blank_ms}) begin
                        n_in_blanking = 1'b0;
                    end
                    if (!n_in_blanking && w_over) begin
                        if (!r_trip_latched) begin
                            n_trip_latched   = 1'b1;
                            n_trip_direction = (r_drive_speed > SPEED_STOP) ? DIR_FWD : DIR_REV;
                        end
                        n_drive_speed = SPEED_STOP;
                    end
                end else begin
                    n_running     = 1'b0;
                    n_in_blanking = 1'b0;
                end
            end

            // command decode
            if (i_pulse.pending) begin
                if (w_in_range) begin
                    if (i_pulse.width < i_cfg.deadzone_low_us) begin
                        w_cmd = SPEED_REV;
                    end else if (i_pulse.width > i_cfg.deadzone_high_us) begin
                        w_cmd = SPEED_FWD;
                    end
                end
                // opposite command releases the trip
                if (n_trip_latched && w_cmd != SPEED_STOP) begin
                    if ((n_trip_direction == DIR_FWD && w_cmd < SPEED_STOP) ||
                        (n_trip_direction == DIR_REV && w_cmd > SPEED_STOP)) begin
                        n_trip_latched = 1'b0;
                    end
                end
                if (n_trip_latched) begin
                    w_cmd = SPEED_STOP;
                end
                if (w_cmd != r_commanded_speed) begin
                    n_commanded_speed = w_cmd;
                    n_drive_speed     = w_cmd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_speed     <= SPEED_STOP;
            r_commanded_speed <= SPEED_STOP;
            r_trip_latched    <= 1'b0;
            r_trip_direction  <= DIR_NONE;
            r_running         <= 1'b0;
            r_start_ms        <= 32'd0;
            r_in_blanking     <= 1'b0;
        end else if (i_step) begin
            r_drive_speed     <= n_drive_speed;
            r_commanded_speed <= n_commanded_speed;
            r_trip_latched    <= n_trip_latched;
            r_trip_direction  <= n_trip_direction;
            r_running         <= n_running;
            r_start_ms        <= n_start_ms;
            r_in_blanking     <= n_in_blanking;
        end
    end

    assign o_motor_next.speed    = n_drive_speed;
    assign o_motor_next.tripped  = n_trip_latched;
    assign o_motor_next.blanking = n_in_blanking;

endmodule

`default_nettype wire

>>> sv/rc_pulse_motor_overcurrent_guard_unit.sv
// top level of the rc pulse motor overcurrent guard: input word register,
// single-pass update and result register; uses rcpmog_pkg, rcpmog_regs,
// rcpmog_pulse and rcpmog_prot
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   in      | i_in_valid / o_in_stall    | i_op i_time_us i_pin_level i_time_ms
//           |                            | i_current_ma
//   out     | o_out_valid / i_out_stall  | o_drive_a o_drive_b o_speed_now o_tripped
//           |                            | o_blanking o_last_width_us
//   cfg     | psel penable pwrite pready | paddr pwdata prdata
//
// one word per cycle sustained while the output is not stalled; an accepted word
// sits in the input register; state updates from it into the result register
// the input register and the result register each hold one word, so input is taken
// while a finished result waits; o_in_stall rises only when both are full
// reset is synchronous and active low and clears state and configuration
`default_nettype none

module rc_pulse_motor_overcurrent_guard_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_op,
    input  wire logic [31:0]                        i_time_us,
    input  wire logic                               i_pin_level,
    input  wire logic [31:0]                        i_time_ms,
    input  wire logic signed [12:0]                 i_current_ma,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [7:0]                         o_drive_a,
    output logic      [7:0]                         o_drive_b,
    output logic signed [8:0]                       o_speed_now,
    output logic                                    o_tripped,
    output logic                                    o_blanking,
    output logic      [15:0]                        o_last_width_us,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rcpmog_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready
);
    import rcpmog_pkg::*;

    t_cfg   w_cfg;
    t_pulse w_pulse;
    t_motor w_motor_next;
    logic [15:0] w_held_next;

    logic               r_in_valid;
    logic               r_op;
    logic [31:0]        r_time_us;
    logic               r_pin_level;
    logic [31:0]        r_time_ms;
    logic signed [12:0] r_current_ma;

    logic               r_out_valid;
    logic [7:0]         r_drive_a;
    logic [7:0]         r_drive_b;
    logic signed [8:0]  r_speed_now;
    logic               r_tripped;
    logic               r_blanking;
    logic [15:0]        r_last_width_us;

    logic               w_step;
    logic               w_in_acc;
    logic signed [8:0]  w_neg_speed;

    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    rcpmog_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rcpmog_pulse u_pulse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_op          (r_op),
        .i_time_us     (r_time_us),
        .i_pin_level   (r_pin_level),
        .i_edge_gap_us (w_cfg.edge_gap_us),
        .o_pulse       (w_pulse),
        .o_held_next   (w_held_next)
    );

    rcpmog_prot u_prot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_op         (r_op),
        .i_time_ms    (r_time_ms),
        .i_current_ma (r_current_ma),
        .i_cfg        (w_cfg),
        .i_pulse      (w_pulse),
        .o_motor_next (w_motor_next)
    );

    assign w_neg_speed = -w_motor_next.speed;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc || (r_in_valid && !w_step);
        end
        if (w_in_acc) begin
            r_op         <= i_op;
            r_time_us    <= i_time_us;
            r_pin_level  <= i_pin_level;
            r_time_ms    <= i_time_ms;
            r_current_ma <= i_current_ma;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_step) begin
            r_drive_a       <= (w_motor_next.speed > SPEED_STOP) ? w_motor_next.speed[7:0] : 8'd0;
            r_drive_b       <= (w_motor_next.speed < SPEED_STOP) ? w_neg_speed[7:0] : 8'd0;
            r_speed_now     <= w_motor_next.speed;
            r_tripped       <= w_motor_next.tripped;
            r_blanking      <= w_motor_next.blanking;
            r_last_width_us <= w_held_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_a       = r_drive_a;
    assign o_drive_b       = r_drive_b;
    assign o_speed_now     = r_speed_now;
    assign o_tripped       = r_tripped;
    assign o_blanking      = r_blanking;
    assign o_last_width_us = r_last_width_us;

    a_trip_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tripped |-> o_speed_now == SPEED_STOP)
        else $error("tripped word with nonzero drive");

    a_one_bridge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_a == 8'd0 || o_drive_b == 8'd0))
        else $error("both half-bridges driven");

    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("processed word not presented");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled with room to spare");

endmodule

`default_nettype wire
